// File: rtl/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types and constants for the rotated, mirrored texel store.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int DIM_W     = 9;   // image dimension registers
  localparam int COORD_W   = 8;   // request coordinates
  localparam int TURN_W    = 16;  // signed quarter-turn count
  localparam int COLOR_W   = 32;  // RGBA8 texel
  localparam int IDX_W     = 18;  // linear index and texel count, up to 511*511
  localparam int MAX_DIM   = 256; // dimension registers saturate here

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2; // front-to-back queue
  localparam int OUT_DEPTH   = 4; // result queue ahead of the output port

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Rotation codes: quarter-turn count modulo four
  localparam logic [1:0] TURN_0   = 2'd0;
  localparam logic [1:0] TURN_90  = 2'd1;
  localparam logic [1:0] TURN_180 = 2'd2;
  localparam logic [1:0] TURN_270 = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // Classified request as it waits between front and back
  typedef struct packed {
    logic               is_write;
    logic               err;
    logic [DIM_W-1:0]   src_x;
    logic [DIM_W-1:0]   src_y;
    logic [COLOR_W-1:0] color;
  } rmts_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               status;
  } rmts_result_t;

endpackage

// File: rtl/rmts_front.sv
// ----------------------------------------------------------------------------
// rmts_front
// Request classifier: bounds check and rotation/mirror mapping of reads to
// source coordinates.
// ----------------------------------------------------------------------------
module rmts_front (
  input  logic                          req_type,
  input  logic [rmts_pkg::COORD_W-1:0]  coord_x,
  input  logic [rmts_pkg::COORD_W-1:0]  coord_y,
  input  logic [1:0]                    turns,
  input  logic                          mirror,
  input  logic [rmts_pkg::COLOR_W-1:0]  write_color,
  input  rmts_pkg::dims_t               dims,
  output rmts_pkg::rmts_item_t          item
);
  import rmts_pkg::*;

  logic [DIM_W-1:0] x9;
  logic [DIM_W-1:0] y9;
  logic [DIM_W-1:0] rot_w;
  logic [DIM_W-1:0] rot_h;
  logic [DIM_W-1:0] map_x;
  logic [DIM_W-1:0] map_y;
  logic             in_bounds;

  assign x9 = {1'b0, coord_x};
  assign y9 = {1'b0, coord_y};

  // Odd turns swap the visible dimensions
  assign rot_w     = turns[0] ? dims.height : dims.width;
  assign rot_h     = turns[0] ? dims.width  : dims.height;
  assign in_bounds = (x9 < rot_w) && (y9 < rot_h);

  always_comb begin
    unique case (turns)
      TURN_90: begin
        map_x = y9;
        map_y = dims.height - x9 - 9'd1;
      end
      TURN_180: begin
        map_x = dims.width  - x9 - 9'd1;
        map_y = dims.height - y9 - 9'd1;
      end
      TURN_270: begin
        map_x = dims.width - y9 - 9'd1;
        map_y = x9;
      end
      TURN_0: begin
        map_x = x9;
        map_y = y9;
      end
      default: begin
        map_x = x9;
        map_y = y9;
      end
    endcase
    if (mirror) begin
      map_x = dims.width - map_x - 9'd1;
    end
  end

  always_comb begin
    item.is_write = (req_type == REQ_WRITE);
    item.color    = write_color;
    if (req_type == REQ_WRITE) begin
      // writes use the raw linear position; the back end checks the index
      item.err   = 1'b0;
      item.src_x = x9;
      item.src_y = y9;
    end else begin
      item.err   = !in_bounds;
      item.src_x = map_x;
      item.src_y = map_y;
    end
  end

endmodule

// File: rtl/rmts_queue.sv
// ----------------------------------------------------------------------------
// rmts_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rmts_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rmts_pkg::rmts_item_t  push_item,
  input  logic                  pop,
  output rmts_pkg::rmts_item_t  head_item,
  output rmts_pkg::queue_stat_t stat
);
  import rmts_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rmts_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// File: rtl/rmts_back.sv
// ----------------------------------------------------------------------------
// rmts_back
// Execution side: linear index, texel memory access and result queue.
// ----------------------------------------------------------------------------
module rmts_back #(
  parameter int MAX_TEXELS = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmts_pkg::rmts_item_t          q_item,
  input  rmts_pkg::queue_stat_t         q_stat,
  output logic                          q_pop,
  input  rmts_pkg::dims_t               dims,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [rmts_pkg::COLOR_W-1:0]  res_color,
  output logic                          res_status
);
  import rmts_pkg::*;

  localparam int ADDR_W = $clog2(MAX_TEXELS);
  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  // Multiply stage
  logic               m_vld_r;
  logic               m_is_write_r;
  logic               m_err_r;
  logic [DIM_W-1:0]   m_src_x_r;
  logic [COLOR_W-1:0] m_color_r;
  logic [IDX_W-1:0]   m_prod_r;
  logic [IDX_W-1:0]   m_total_r;

  // Memory stage
  logic               r_vld_r;
  logic               r_rd_ok_r;
  logic               r_err_r;
  logic [COLOR_W-1:0] rd_data_r;

  logic [COLOR_W-1:0] mem [MAX_TEXELS];

  logic [IDX_W-1:0]   idx;
  logic [31:0]        idx_ext;
  logic [ADDR_W-1:0]  addr;
  logic               idx_err;
  logic               mem_we;
  logic               mem_re;

  // Result queue
  rmts_result_t       ofifo_r [OUT_DEPTH];
  logic [OPTR_W-1:0]  o_wr_r, o_wr_nxt;
  logic [OPTR_W-1:0]  o_rd_r, o_rd_nxt;
  logic [OCNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic               o_push;
  logic               o_pop;
  rmts_result_t       o_push_res;
  logic [OCNT_W:0]    used;

  // Issue against free room in the result queue, counting what is in flight
  assign o_pop = res_valid && res_ready;
  assign used  = (OCNT_W+1)'(m_vld_r) + (OCNT_W+1)'(r_vld_r) + {1'b0, o_cnt_r}
               - (OCNT_W+1)'(o_pop);
  assign q_pop = !q_stat.empty && (used < (OCNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_is_write_r <= q_item.is_write;
      m_err_r      <= q_item.err;
      m_src_x_r    <= q_item.src_x;
      m_color_r    <= q_item.color;
      m_prod_r     <= IDX_W'(q_item.src_y) * IDX_W'(dims.width);
      m_total_r    <= IDX_W'(dims.width) * IDX_W'(dims.height);
    end
  end

  assign idx     = m_prod_r + IDX_W'(m_src_x_r);
  assign idx_ext = {{(32-IDX_W){1'b0}}, idx};
  assign addr    = idx_ext[ADDR_W-1:0];
  assign idx_err = m_err_r || (idx >= m_total_r) || (idx_ext >= 32'(MAX_TEXELS));
  assign mem_we  = m_vld_r && m_is_write_r && !idx_err;
  assign mem_re  = m_vld_r && !m_is_write_r && !idx_err;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= m_color_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_vld_r) begin
      r_rd_ok_r <= !m_is_write_r && !idx_err;
      r_err_r   <= idx_err;
    end
  end

  assign o_push           = r_vld_r;
  assign o_push_res.color = r_rd_ok_r ? rd_data_r : '0;
  assign o_push_res.status = r_err_r;

  always_comb begin
    o_wr_nxt  = o_wr_r;
    o_rd_nxt  = o_rd_r;
    o_cnt_nxt = o_cnt_r;
    if (o_push) begin
      o_wr_nxt = (o_wr_r == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_wr_r + 1'b1;
    end
    if (o_pop) begin
      o_rd_nxt = (o_rd_r == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_rd_r + 1'b1;
    end
    if (o_push && !o_pop) begin
      o_cnt_nxt = o_cnt_r + 1'b1;
    end else if (o_pop && !o_push) begin
      o_cnt_nxt = o_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_r  <= '0;
      o_rd_r  <= '0;
      o_cnt_r <= '0;
    end else begin
      o_wr_r  <= o_wr_nxt;
      o_rd_r  <= o_rd_nxt;
      o_cnt_r <= o_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofifo_r[o_wr_r] <= o_push_res;
    end
  end

  assign res_valid  = (o_cnt_r != '0);
  assign res_color  = ofifo_r[o_rd_r].color;
  assign res_status = ofifo_r[o_rd_r].status;

endmodule

// File: rtl/rotated_mirrored_texel_store_unit.sv
// ----------------------------------------------------------------------------
// rotated_mirrored_texel_store_unit
// Image store of RGBA8 texels with rotated and mirrored read addressing.
// ----------------------------------------------------------------------------
// Holds an image of MAX_TEXELS 32-bit texels, sized by the image_width and
// image_height registers (0..256, reset 256, larger values saturate). A write
// transaction stores write_color at x + y*width; a read transaction takes a
// coordinate in the view turned by quarter_turns (modulo four, negative
// counts included) and optionally mirrored, and returns that texel. Every
// transaction gives exactly one result, in order; status 1 means the
// coordinate or index was out of range, nothing was done, and the color is
// zero. Sustained rate is one transaction per clock while out_tready holds
// high: a request is classified on input and parked in a two-entry queue,
// then goes through a multiply stage (row times width) and the single-port
// texel memory with a registered read. Issue from the queue is credited
// against a four-entry result queue, so output stalls never drop a result.
// The memory is not cleared after reset; read only texels that were written.
// Change the dimension registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module rotated_mirrored_texel_store_unit #(
  parameter int MAX_TEXELS = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, from bit 0: coord_x[7:0], coord_y[15:8], quarter_turns[31:16],
  // mirror[32], write_color[64:33], zero pad[71:65]
  input  logic [rmts_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: req_type (0 read, 1 write)
  input  logic                              in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, from bit 0: read_color[31:0]
  output logic [rmts_pkg::OUT_DATA_W-1:0]   out_tdata,
  // tuser: status (0 ok, 1 out of bounds)
  output logic                              out_tuser,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [rmts_pkg::DIM_W-1:0]        cfg_wdata
);
  import rmts_pkg::*;

  localparam logic [DIM_W-1:0] DIM_RESET = (256 > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(256);

  dims_t            dims_r;
  logic [DIM_W-1:0] cfg_sat;

  rmts_item_t       front_item;
  rmts_item_t       q_head;
  queue_stat_t      q_stat;
  logic             q_push;
  logic             q_pop;

  // Clamp written dimensions to the largest supported image
  assign cfg_sat = (32'(cfg_wdata) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.width  <= DIM_RESET;
      dims_r.height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  dims_r.width  <= cfg_sat;
        CFG_IMAGE_HEIGHT: dims_r.height <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room; the front classifies in the same cycle
  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  rmts_front u_front (
    .req_type    (in_tuser),
    .coord_x     (in_tdata[7:0]),
    .coord_y     (in_tdata[15:8]),
    .turns       (in_tdata[17:16]), // floor mod 4 of the signed count
    .mirror      (in_tdata[32]),
    .write_color (in_tdata[64:33]),
    .dims        (dims_r),
    .item        (front_item)
  );

  rmts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (q_head),
    .stat      (q_stat)
  );

  rmts_back #(
    .MAX_TEXELS (MAX_TEXELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .dims       (dims_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_color  (out_tdata),
    .res_status (out_tuser)
  );

`ifndef SYNTHESIS
  // Failed transactions never carry texel data
  a_err_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result with nonzero color");

  // The back end only issues from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("issue from empty request queue");

  // Reset flushes all pending results
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

// File: tb/rotated_mirrored_texel_store_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_mirrored_texel_store_unit_checker
// Scoreboard for the rotated, mirrored texel store.
// ----------------------------------------------------------------------------
// Watches the configuration port and both stream channels. Keeps a texel
// image and the image size of its own, works out the texel and status of
// every accepted request, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module rotated_mirrored_texel_store_unit_checker #(
  parameter int MAX_TEXELS = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rmts_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rmts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [rmts_pkg::DIM_W-1:0]      cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import rmts_pkg::*;

  logic [COLOR_W-1:0] texel_mem [MAX_TEXELS];
  logic [DIM_W-1:0]   img_w;
  logic [DIM_W-1:0]   img_h;
  rmts_result_t       expected_texels[$];
  int                 errors = 0;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

  // Apply one request to the local image and return its result.
  function automatic rmts_result_t predict_texel_access(logic is_write, logic [7:0] x,
                                                        logic [7:0] y, logic [1:0] turn,
                                                        logic mir, logic [31:0] color);
    int unsigned  w, h, total, idx, sx, sy, rw, rh;
    rmts_result_t res;
    w = img_w;
    h = img_h;
    total = w * h;
    res.color  = '0;
    res.status = 1'b1;
    if (is_write == REQ_WRITE) begin
      idx = x + y * w;
      if (idx < total && idx < MAX_TEXELS) begin
        texel_mem[idx] = color;
        res.status = 1'b0;
      end
      return res;
    end
    // odd turns swap the visible width and height
    rw = turn[0] ? h : w;
    rh = turn[0] ? w : h;
    if (x >= rw || y >= rh) return res;
    case (turn)
      TURN_90: begin
        sx = y;
        sy = h - 1 - x;
      end
      TURN_180: begin
        sx = w - 1 - x;
        sy = h - 1 - y;
      end
      TURN_270: begin
        sx = w - 1 - y;
        sy = x;
      end
      default: begin
        sx = x;
        sy = y;
      end
    endcase
    if (mir) sx = w - 1 - sx;
    idx = sx + sy * w;
    if (idx >= total || idx >= MAX_TEXELS) return res;
    res.color  = texel_mem[idx];
    res.status = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    rmts_result_t want;
    logic [15:0]  turns_in;
    if (!rst_n) begin
      expected_texels.delete();
      img_w = DIM_W'(MAX_DIM);
      img_h = DIM_W'(MAX_DIM);
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_IMAGE_WIDTH) img_w = clamp_dim(cfg_wdata);
        else if (cfg_addr == CFG_IMAGE_HEIGHT) img_h = clamp_dim(cfg_wdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_texels.size() == 0) begin
          $display("%0t: unexpected result, color %h status %b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = expected_texels.pop_front();
          if (out_tdata !== want.color) begin
            $display("%0t: read_color expected %h, got %h", $time, want.color, out_tdata);
            errors++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %b, got %b", $time, want.status, out_tuser);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        turns_in = in_tdata[31:16];
        want = predict_texel_access(in_tuser, in_tdata[7:0], in_tdata[15:8],
                                    turns_in[1:0], in_tdata[32], in_tdata[64:33]);
        expected_texels = {expected_texels, want};
      end
    end
    pending    <= expected_texels.size();
    fail_count <= errors;
  end

endmodule

// File: tb/rotated_mirrored_texel_store_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_mirrored_texel_store_unit_tb
// Stimulus and verdict for the rotated, mirrored texel store.
// ----------------------------------------------------------------------------
// Loads texels by write transactions and reads them back through every
// rotation and mirror setting, over a series of image sizes that includes
// the smallest, the largest, saturated and zero sizes. A directed opening
// covers corners, extreme turn counts and the error cases; random traffic
// follows with random gaps on both channels. The checker beside the block
// does all the comparing.
// ----------------------------------------------------------------------------
module rotated_mirrored_texel_store_unit_tb;
  import rmts_pkg::*;

  localparam int MAX_TEXELS = 65536;
  localparam int LIMIT      = 400000; // cycles before the run is declared hung
  localparam int LONG_STALL = 80;     // one long output hold-off, in cycles
  localparam int NUM_PHASES = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // tdata, from bit 0: coord_x, coord_y, quarter_turns, mirror, write_color, pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // tuser: req_type
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // tdata, from bit 0: read_color
  logic [OUT_DATA_W-1:0] out_tdata;
  // tuser: status
  logic                  out_tuser;
  logic                  cfg_we;
  logic                  cfg_addr;
  logic [DIM_W-1:0]      cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;

  // Pacing knobs, changed per phase by the stimulus process
  bit in_fast     = 1'b0;
  bit out_fast    = 1'b0;
  bit stall_burst = 1'b0;

  // What the image size currently is, and which texels hold known data
  int unsigned img_w;
  int unsigned img_h;
  bit          loaded [MAX_TEXELS];
  int unsigned loaded_idx[$];

  // Image sizes as written to the registers; some saturate, some are zero
  logic [DIM_W-1:0] phase_w     [NUM_PHASES] = '{256, 5, 1,   1, 256, 0, 9, 511, 16, 200, 3, 257};
  logic [DIM_W-1:0] phase_h     [NUM_PHASES] = '{256, 3, 1, 256,   1, 7, 0, 300, 16, 100, 5,   2};
  int               phase_items [NUM_PHASES] = '{300, 150, 60, 120, 120, 40, 40, 250, 200, 250,
                                                 120, 100};

  rotated_mirrored_texel_store_unit #(
    .MAX_TEXELS (MAX_TEXELS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  rotated_mirrored_texel_store_unit_checker #(
    .MAX_TEXELS (MAX_TEXELS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[rotated_mirrored_texel_store_unit] ERROR");
      $finish;
    end
  end

  // Result receiver: random back-pressure per transaction, plus one long hold
  // on request so that both internal queues fill and the input stalls.
  initial begin : receiver
    int gap;
    bit burst_done;
    out_tready = 1'b0;
    burst_done = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (stall_burst && !burst_done) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        burst_done = 1'b1;
      end
      gap = out_fast ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one request and hold it until the block takes it. Track which
  // texels a successful write has filled, so reads only touch known data.
  task automatic send_req(input logic is_write, input logic [7:0] x, input logic [7:0] y,
                          input logic [15:0] turns, input logic mir,
                          input logic [31:0] color);
    int          gap;
    int unsigned idx;
    gap = in_fast ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_write;
    in_tdata  <= {7'b0, color, mir, turns, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (is_write == REQ_WRITE) begin
      idx = x + y * img_w;
      if (idx < img_w * img_h && !loaded[idx]) begin
        loaded[idx] = 1'b1;
        loaded_idx = {loaded_idx, idx};
      end
    end
  endtask

  // Drop valid and wait until every result is back and the pipe is empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both dimension registers back to back; hold enable across both.
  task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    img_w = (w > MAX_DIM) ? MAX_DIM : w;
    img_h = (h > MAX_DIM) ? MAX_DIM : h;
  endtask

  // One random request. Reads mostly target a loaded texel: pick its source
  // position and walk the mirror and rotation backwards to a view coordinate.
  // A fifth of reads use a random coordinate, kept only when it falls outside
  // the turned view. Writes mostly land inside the image.
  task automatic random_item();
    int unsigned total, pick, sx, sy, c;
    logic [7:0]  x, y;
    logic [15:0] turns;
    logic        mir, found, odd;
    int          tries;
    total = img_w * img_h;
    x     = $urandom;
    y     = $urandom;
    turns = $urandom;
    mir   = $urandom;
    odd   = turns[0];
    found = 1'b0;
    if ($urandom_range(0, 99) < 55) begin
      if (total == 0 || ($urandom_range(0, 9) < 2 &&
          !(x < (odd ? img_h : img_w) && y < (odd ? img_w : img_h)))) begin
        send_req(REQ_READ, x, y, turns, mir, $urandom);
        return;
      end
      for (tries = 0; tries < 16 && !found && loaded_idx.size() > 0; tries++) begin
        pick  = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        found = (pick < total);
      end
      if (found) begin
        sx = pick % img_w;
        sy = pick / img_w;
        c  = mir ? img_w - 1 - sx : sx;
        case (turns[1:0])
          TURN_90: begin
            x = img_h - 1 - sy;
            y = c;
          end
          TURN_180: begin
            x = img_w - 1 - c;
            y = img_h - 1 - sy;
          end
          TURN_270: begin
            x = sy;
            y = img_w - 1 - c;
          end
          default: begin
            x = c;
            y = sy;
          end
        endcase
        send_req(REQ_READ, x, y, turns, mir, $urandom);
        return;
      end
    end
    // write path, also taken when no usable texel is loaded yet: fill one
    if (total > 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, total - 1);
      x = pick % img_w;
      y = pick / img_w;
    end
    send_req(REQ_WRITE, x, y, turns, mir, $urandom);
  endtask

  initial begin : stimulus
    int p;
    int n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_READ;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    img_w     = MAX_DIM;
    img_h     = MAX_DIM;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full-size image after reset: load the four corners, then read them
    // through every turn, negative and extreme counts, with and without mirror.
    send_req(REQ_WRITE, 8'd0,   8'd0,   16'h8000, 1'b1, 32'hFFFF_FFFF);
    send_req(REQ_WRITE, 8'd255, 8'd255, 16'h7FFF, 1'b0, 32'h0000_0000);
    send_req(REQ_WRITE, 8'd255, 8'd0,   16'h0000, 1'b0, 32'hA5C3_5A3C);
    send_req(REQ_WRITE, 8'd0,   8'd255, 16'hFFFF, 1'b1, 32'h8000_0001);
    send_req(REQ_READ,  8'd0,   8'd0,   16'h0000, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd0,   8'd0,   16'h0001, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd0,   8'd0,   16'h0002, 1'b1, 32'h0);
    send_req(REQ_READ,  8'd0,   8'd0,   16'h0003, 1'b1, 32'h0);
    send_req(REQ_READ,  8'd255, 8'd0,   16'hFFFF, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd0,   8'd255, 16'h7FFF, 1'b1, 32'h0);
    send_req(REQ_READ,  8'd255, 8'd255, 16'h8000, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd255, 8'd255, 16'hFFFE, 1'b1, 32'hFFFF_FFFF);
    send_req(REQ_READ,  8'd0,   8'd255, 16'h0005, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd255, 8'd0,   16'h0006, 1'b1, 32'h0);

    // 4x3 image: a write past the row end still lands inside, one past the
    // last texel fails, a read beyond the turned width fails.
    wait_idle();
    set_dims(9'd4, 9'd3);
    send_req(REQ_WRITE, 8'd6,   8'd1,   16'h0000, 1'b0, 32'h1234_5678);
    send_req(REQ_WRITE, 8'd0,   8'd3,   16'h0000, 1'b0, 32'hDEAD_BEEF);
    send_req(REQ_WRITE, 8'd255, 8'd255, 16'h0000, 1'b0, 32'hDEAD_BEEF);
    send_req(REQ_READ,  8'd2,   8'd2,   16'h0000, 1'b0, 32'h0);
    send_req(REQ_READ,  8'd3,   8'd0,   16'h0001, 1'b0, 32'h0);

    // Zero width: everything fails
    wait_idle();
    set_dims(9'd0, 9'd5);
    send_req(REQ_WRITE, 8'd0, 8'd0, 16'h0000, 1'b0, 32'h0BAD_F00D);
    send_req(REQ_READ,  8'd0, 8'd0, 16'h0001, 1'b0, 32'h0);

    // Random phases over a range of image sizes
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_dims(phase_w[p], phase_h[p]);
      in_fast  = ($urandom_range(0, 3) == 0) || (p == 0);
      out_fast = ($urandom_range(0, 3) == 0);
      // first phase: long output hold while requests keep coming
      if (p == 0) stall_burst = 1'b1;
      for (n = 0; n < phase_items[p]; n++) begin
        // pause mid-phase until the block has drained completely
        if (p == 0 && n == phase_items[p] / 2) wait_idle();
        random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[rotated_mirrored_texel_store_unit] OK");
    end else begin
      $display("[rotated_mirrored_texel_store_unit] ERROR");
    end
    $finish;
  end

endmodule
